/* design/drcr_pkg.sv */
// Package for the drive command ramp controller: payload structs, codes,
// register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package drcr_pkg;

   // Command bytes.
   localparam logic [7:0] CMD_FORWARD = 8'h46;  // 'F'
   localparam logic [7:0] CMD_BACK    = 8'h42;  // 'B'
   localparam logic [7:0] CMD_LEFT    = 8'h4C;  // 'L'
   localparam logic [7:0] CMD_RIGHT   = 8'h52;  // 'R'

   // Configuration register indexes.
   localparam int unsigned CsrIndexWidth = 2;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_SPEED     = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_RAMP_STEP     = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_REPORT_PERIOD = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_FULL_SCALE    = 2'd3;

   localparam logic [7:0] MAX_SPEED_RESET     = 8'd200;
   localparam logic [7:0] RAMP_STEP_RESET     = 8'd5;
   localparam logic [7:0] REPORT_PERIOD_RESET = 8'd6;
   localparam logic [7:0] FULL_SCALE_RESET    = 8'd60;

   typedef enum logic [2:0] {
      HEAD_STOP  = 3'd0,
      HEAD_FWD   = 3'd1,
      HEAD_BACK  = 3'd2,
      HEAD_LEFT  = 3'd3,
      HEAD_RIGHT = 3'd4
   } heading_type;

   typedef enum logic [1:0] {
      AXIAL_STOP = 2'd0,
      AXIAL_FWD  = 2'd1,
      AXIAL_BACK = 2'd2
   } axial_type;

   localparam logic [2:0] ACT_NONE     = 3'd0;
   localparam logic [2:0] ACT_FORWARD  = 3'd1;
   localparam logic [2:0] ACT_BACKWARD = 3'd2;
   localparam logic [2:0] ACT_LEFT     = 3'd3;
   localparam logic [2:0] ACT_RIGHT    = 3'd4;
   localparam logic [2:0] ACT_STOP     = 3'd5;

   typedef struct packed {
      logic       command_valid;
      logic [7:0] command_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] drive_action;
      logic [7:0] drive_level;
      logic       reversal_stop;
      logic       report_valid;
      logic [4:0] report_whole;
      logic [3:0] report_tenth;
   } rsp_type;

   typedef struct packed {
      logic [7:0] max_speed;
      logic [7:0] ramp_step;
      logic [7:0] report_period;
      logic [7:0] full_scale_tenths;
   } cfg_type;

   // Word between the control stage and the speed scaling stage.
   typedef struct packed {
      logic [2:0]  drive_action;
      logic [7:0]  drive_level;
      logic        reversal_stop;
      logic        report_valid;
      logic [15:0] scaled_product;
   } mid_type;

endpackage

/* design/drive_command_ramp_controller.sv */
// Top level of the drive command ramp controller: configuration registers
// and the three-stage word pipeline. Depends on drcr_pkg, drcr_ctrl and
// drcr_speed_scale.
//
//   channel | direction | handshake          | word
//   req     | in        | req_valid/req_stall | command_valid, command_byte
//   rsp     | out       | rsp_valid/rsp_stall | action, level, flags, report
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One word per cycle sustained while rsp is not stalled; a word reaches rsp
// through the input register, control stage register and output register.
// The ramp and report state update as a word leaves the input register.
// Synchronous reset empties the pipeline and restores state and registers.
// Each stage holds its word only while the stage after it is full and held,
// so up to three words are taken while rsp is stalled.
`timescale 1ns / 1ps

module drive_command_ramp_controller (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  drcr_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output drcr_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [drcr_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [7:0]                            csr_data
);
   import drcr_pkg::*;

   cfg_type cfg_ff;
   req_type in_data_ff;
   logic    in_valid_ff;
   mid_type mid_data_ff, mid_data_in;
   logic    mid_valid_ff;
   rsp_type out_data_ff, out_data_in;
   logic    out_valid_ff;

   logic out_move, mid_move, in_move;

   assign out_move  = !out_valid_ff || !rsp_stall;
   assign mid_move  = !mid_valid_ff || out_move;
   assign in_move   = !in_valid_ff || mid_move;
   assign req_stall = !in_move;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed         <= MAX_SPEED_RESET;
         cfg_ff.ramp_step         <= RAMP_STEP_RESET;
         cfg_ff.report_period     <= REPORT_PERIOD_RESET;
         cfg_ff.full_scale_tenths <= FULL_SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_SPEED:     cfg_ff.max_speed         <= csr_data;
            CSR_RAMP_STEP:     cfg_ff.ramp_step         <= csr_data;
            CSR_REPORT_PERIOD: cfg_ff.report_period     <= csr_data;
            CSR_FULL_SCALE:    cfg_ff.full_scale_tenths <= csr_data;
            default:           ;
         endcase
      end
   end

   drcr_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .item    (in_data_ff),
      .advance (in_valid_ff && mid_move),
      .result  (mid_data_in)
   );

   drcr_speed_scale u_scale (
      .stage  (mid_data_ff),
      .result (out_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_move) in_valid_ff <= req_valid;
         if (mid_move) mid_valid_ff <= in_valid_ff;
         if (out_move) out_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_move) in_data_ff <= req_data;
      if (mid_move) mid_data_ff <= mid_data_in;
      if (out_move) out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

/* design/drcr_ctrl.sv */
// Control stage: heading, target, ramp and report counter state, plus the
// level times full-scale product. Depends on drcr_pkg.
`timescale 1ns / 1ps

module drcr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  drcr_pkg::cfg_type cfg,
   input  drcr_pkg::req_type item,
   input  logic             advance,
   output drcr_pkg::mid_type result
);
   import drcr_pkg::*;

   heading_type heading_ff, heading_in;
   axial_type   axial_ff, axial_in;
   logic [7:0]  target_ff, target_in;
   logic [7:0]  level_ff, level_in;
   logic [7:0]  count_ff, count_in;

   logic        reversal;
   logic [7:0]  base_level;
   logic [7:0]  diff;
   logic [8:0]  count_inc;
   logic        report_due;

   always_comb begin
      heading_in = heading_ff;
      axial_in   = axial_ff;
      target_in  = target_ff;
      reversal   = 1'b0;
      if (item.command_valid) begin
         reversal = (axial_ff == AXIAL_FWD && item.command_byte == CMD_BACK) ||
                    (axial_ff == AXIAL_BACK && item.command_byte == CMD_FORWARD);
         case (item.command_byte)
            CMD_FORWARD: begin
               heading_in = HEAD_FWD;
               axial_in   = AXIAL_FWD;
               target_in  = cfg.max_speed;
            end
            CMD_BACK: begin
               heading_in = HEAD_BACK;
               axial_in   = AXIAL_BACK;
               target_in  = cfg.max_speed;
            end
            CMD_LEFT: begin
               heading_in = HEAD_LEFT;
               target_in  = cfg.max_speed;
            end
            CMD_RIGHT: begin
               heading_in = HEAD_RIGHT;
               target_in  = cfg.max_speed;
            end
            default: begin
               heading_in = HEAD_STOP;
               axial_in   = AXIAL_STOP;
               target_in  = 8'd0;
            end
         endcase
      end

      // A reversal drops the level to zero before the ramp runs.
      base_level = reversal ? 8'd0 : level_ff;
      level_in   = base_level;
      diff       = 8'd0;
      if (base_level < target_in) begin
         diff     = target_in - base_level;
         level_in = (diff > cfg.ramp_step) ? base_level + cfg.ramp_step : target_in;
      end else if (base_level > target_in) begin
         diff     = base_level - target_in;
         level_in = (diff > cfg.ramp_step) ? base_level - cfg.ramp_step : target_in;
      end

      count_inc  = {1'b0, count_ff} + 9'd1;
      report_due = count_inc >= {1'b0, cfg.report_period};
      count_in   = report_due ? 8'd0 : count_inc[7:0];

      case (heading_in)
         HEAD_FWD:   result.drive_action = ACT_FORWARD;
         HEAD_BACK:  result.drive_action = ACT_BACKWARD;
         HEAD_LEFT:  result.drive_action = ACT_LEFT;
         HEAD_RIGHT: result.drive_action = ACT_RIGHT;
         default:    result.drive_action = (level_in == 8'd0) ? ACT_STOP : ACT_NONE;
      endcase
      result.drive_level    = level_in;
      result.reversal_stop  = reversal;
      result.report_valid   = report_due;
      result.scaled_product = report_due ? level_in * cfg.full_scale_tenths : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff <= HEAD_STOP;
         axial_ff   <= AXIAL_STOP;
         target_ff  <= 8'd0;
         level_ff   <= 8'd0;
         count_ff   <= 8'd0;
      end else if (advance) begin
         heading_ff <= heading_in;
         axial_ff   <= axial_in;
         target_ff  <= target_in;
         level_ff   <= level_in;
         count_ff   <= count_in;
      end
   end

endmodule

/* design/drcr_speed_scale.sv */
// Speed scaling stage: divides the registered product by 255 and splits the
// tenths value into whole and tenth digits. Depends on drcr_pkg.
`timescale 1ns / 1ps

module drcr_speed_scale (
   input  drcr_pkg::mid_type stage,
   output drcr_pkg::rsp_type result
);
   import drcr_pkg::*;

   logic [16:0] div_sum;
   logic [7:0]  tenths;
   logic [15:0] recip_prod;
   logic [4:0]  whole;
   logic [7:0]  whole_x10;

   always_comb begin
      // Exact floor(x / 255) for every x below 65280.
      div_sum    = {1'b0, stage.scaled_product} + {9'd0, stage.scaled_product[15:8]} + 17'd1;
      tenths     = div_sum[15:8];
      // floor(t / 10) = (t * 205) >> 11 holds for all 8-bit t.
      recip_prod = tenths * 8'd205;
      whole      = recip_prod[15:11];
      whole_x10  = {whole[4:0], 3'b000} + {2'b00, whole, 1'b0};

      result.drive_action  = stage.drive_action;
      result.drive_level   = stage.drive_level;
      result.reversal_stop = stage.reversal_stop;
      result.report_valid  = stage.report_valid;
      result.report_whole  = stage.report_valid ? whole : 5'd0;
      result.report_tenth  = stage.report_valid ? 4'(tenths - whole_x10) : 4'd0;
   end

endmodule

/* design/drcr_checker.sv */
// Port-level checker for the drive command ramp controller, bound to the
// top level. Depends on drcr_pkg.
`timescale 1ns / 1ps

module drcr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input drcr_pkg::rsp_type                   rsp_data
);
   import drcr_pkg::*;

   // A held result word stays put until it is taken.
   held_word_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // Reset leaves the result side empty.
   reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Report digits are only shown with a report, and stay in decimal range.
   report_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.report_valid ||
                     (rsp_data.report_whole == 5'd0 && rsp_data.report_tenth == 4'd0)) &&
                    rsp_data.report_tenth <= 4'd9 && rsp_data.report_whole <= 5'd25)
      else $error("bad speed report digits");

   // Stop motors only once the level has reached zero.
   stop_at_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.drive_action == ACT_STOP |-> rsp_data.drive_level == 8'd0)
      else $error("stop issued with nonzero level");

   // A reversal comes only with a forward or backward command.
   reversal_axial: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reversal_stop |->
         rsp_data.drive_action == ACT_FORWARD || rsp_data.drive_action == ACT_BACKWARD)
      else $error("reversal flag without axial action");

endmodule

bind drive_command_ramp_controller drcr_checker u_drcr_checker (.*);
